/* rtl/core/moving_average_ring_filter_core_assert.svh */
// Assertion macros shared by the moving average filter RTL.
// Needs nothing else; included by the modules that check their own logic.
`ifndef MOVING_AVERAGE_RING_FILTER_CORE_ASSERT_SVH
`define MOVING_AVERAGE_RING_FILTER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MAVG_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mavg: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define MAVG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mavg: next-cycle check failed");

`endif

/* rtl/core/mavg_pkg.sv */
// Shared types and fixed widths for the moving average filter.
// No dependencies; imported by every module of the block.
`default_nettype none

package mavg_pkg;

  localparam int SAMPLE_W  = 12;
  localparam int PREFILL_W = 3;

  // Pipeline control from the top level to the window and divider stages
  typedef struct packed {
    logic accept;   // input transfer this cycle, window state updates
    logic advance;  // window sum moves into the output register
  } mavg_ctl_t;

endpackage

`default_nettype wire

/* rtl/core/mavg_window.sv */
// Sample ring, running sum, write position and prefill tracking.
// Depends on mavg_pkg and the assertion macro header.
`default_nettype none
`include "moving_average_ring_filter_core_assert.svh"

module mavg_window import mavg_pkg::*; #(
  parameter int WINDOW        = 100,
  parameter int PREFILL_COUNT = 5,
  parameter int SUM_W         = 19
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire mavg_ctl_t           ctl,
  input  wire logic [SAMPLE_W-1:0] sample,
  output logic      [SUM_W-1:0]    sum
);

  localparam int AW    = $clog2(WINDOW);
  localparam int CNT_W = $clog2(WINDOW + 1);

  logic [SAMPLE_W-1:0]  mem [WINDOW];
  logic [SAMPLE_W-1:0]  rd_data_r;
  logic [SAMPLE_W-1:0]  base_r;
  logic [AW-1:0]        wp_r, wp_nxt, wp_inc, rd_addr;
  logic [PREFILL_W-1:0] prefill_r, prefill_nxt;
  logic [CNT_W-1:0]     fill_r, fill_nxt;
  logic [SUM_W-1:0]     sum_r, sum_nxt;
  logic [SAMPLE_W-1:0]  old_sample;
  logic                 prefill_act;

  assign prefill_act = (prefill_r != '0);
  assign wp_inc      = (wp_r == AW'(WINDOW - 1)) ? '0 : wp_r + AW'(1);

  // Entries not yet rewritten after prefill count as the last prefill sample
  assign old_sample = (fill_r == CNT_W'(WINDOW)) ? rd_data_r : base_r;

  always_comb begin
    wp_nxt      = wp_r;
    prefill_nxt = prefill_r;
    fill_nxt    = fill_r;
    sum_nxt     = sum_r;
    if (ctl.accept) begin
      wp_nxt = wp_inc;
      if (prefill_act) begin
        prefill_nxt = prefill_r - PREFILL_W'(1);
        sum_nxt     = SUM_W'(sample) * SUM_W'(WINDOW);
      end else begin
        sum_nxt = sum_r - SUM_W'(old_sample) + SUM_W'(sample);
        if (fill_r != CNT_W'(WINDOW)) begin
          fill_nxt = fill_r + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r      <= '0;
      prefill_r <= PREFILL_W'(PREFILL_COUNT);
      fill_r    <= '0;
      sum_r     <= '0;
    end else begin
      wp_r      <= wp_nxt;
      prefill_r <= prefill_nxt;
      fill_r    <= fill_nxt;
      sum_r     <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept && prefill_act) begin
      base_r <= sample;
    end
  end

  // Prefetch the entry that the next transfer retires
  assign rd_addr = ctl.accept ? wp_inc : wp_r;

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      mem[wp_r] <= sample;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign sum = sum_r;

  `MAVG_ASSERT_NOW(a_no_fill_in_prefill, clk, rst_n, prefill_r != '0, fill_r == '0)
  `MAVG_ASSERT_NOW(a_wp_in_range, clk, rst_n, 1'b1, wp_r <= AW'(WINDOW - 1))

endmodule

`default_nettype wire

/* rtl/core/mavg_div.sv */
// Division of the running sum by the window length, as a reciprocal multiply.
// Depends on mavg_pkg; holds the output payload register.
`default_nettype none

module mavg_div import mavg_pkg::*; #(
  parameter int WINDOW = 100,
  parameter int SUM_W  = 19
) (
  input  wire logic                clk,
  input  wire mavg_ctl_t           ctl,
  input  wire logic [SUM_W-1:0]    sum,
  output logic      [SAMPLE_W-1:0] mean
);

  // floor(n / W) == floor(n * ceil(2^SH / W) / 2^SH) for every n below 2^SUM_W
  localparam int          LOG_W     = $clog2(WINDOW);
  localparam int          SH        = SUM_W + LOG_W;
  localparam int          MW        = SUM_W + 1;
  localparam int          PROD_W    = SUM_W + MW;
  localparam logic [63:0] RECIP_ALL = ((64'd1 << SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam logic [MW-1:0] RECIP   = RECIP_ALL[MW-1:0];

  logic [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (ctl.advance) begin
      prod_r <= PROD_W'(sum) * PROD_W'(RECIP);
    end
  end

  assign mean = prod_r[SH +: SAMPLE_W];

endmodule

`default_nettype wire

/* rtl/core/moving_average_ring_filter_core.sv */
// Boxcar moving average over 12-bit converter samples: handshake and pipeline control.
// Depends on mavg_pkg, mavg_window, mavg_div and the assertion macro header.
`default_nettype none
`include "moving_average_ring_filter_core_assert.svh"

// One sample is taken per clock while in_stall is low, and every sample
// yields one mean, the truncated average of the last WINDOW samples. A
// sample transferred at one edge updates the running sum at that edge. The
// reciprocal multiply then loads the output register when that register is
// free, and the result is offered from it. One result follows per cycle
// while out_stall is low.
// The window sum register and the output register each hold one item, so
// one new sample can be taken while a result waits. For the first
// PREFILL_COUNT samples after reset the output equals the input and those
// samples seed the whole window. The sample ring is a single-port-write
// memory that needs no clearing pass; the block is ready right after reset.
module moving_average_ring_filter_core import mavg_pkg::*; #(
  parameter int WINDOW        = 100,
  parameter int PREFILL_COUNT = 5
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [SAMPLE_W-1:0] in_sample,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic      [SAMPLE_W-1:0] out_mean
);

  localparam int SUM_W = $clog2(((1 << SAMPLE_W) - 1) * WINDOW + 1);

  mavg_ctl_t        ctl;
  logic             s1_valid_r, s1_valid_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;
  logic [SUM_W-1:0] sum;

  assign out_free    = !out_valid_r || !out_stall;
  assign ctl.advance = s1_valid_r && out_free;
  assign in_stall    = s1_valid_r && !out_free;
  assign ctl.accept  = in_valid && !in_stall;

  assign s1_valid_nxt  = ctl.accept || (s1_valid_r && !ctl.advance);
  assign out_valid_nxt = ctl.advance || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  mavg_window #(
    .WINDOW        (WINDOW),
    .PREFILL_COUNT (PREFILL_COUNT),
    .SUM_W         (SUM_W)
  ) u_window (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .sample (in_sample),
    .sum    (sum)
  );

  mavg_div #(
    .WINDOW (WINDOW),
    .SUM_W  (SUM_W)
  ) u_div (
    .clk  (clk),
    .ctl  (ctl),
    .sum  (sum),
    .mean (out_mean)
  );

  assign out_valid = out_valid_r;

  `MAVG_ASSERT_NOW(a_no_stall_when_empty, clk, rst_n, !s1_valid_r, !in_stall)
  `MAVG_ASSERT_NOW(a_full_accept_moves, clk, rst_n, ctl.accept && s1_valid_r, ctl.advance)
  `MAVG_ASSERT_NEXT(a_advance_fills_out, clk, rst_n, ctl.advance, out_valid_r)

endmodule

`default_nettype wire

/* bench/moving_average_ring_filter_core_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the moving average filter: follows every sample transfer,
// predicts its mean and compares it with the result channel. Uses mavg_pkg widths.
module moving_average_ring_filter_core_checker import mavg_pkg::*; #(
  parameter int WINDOW        = 100,
  parameter int PREFILL_COUNT = 5
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic [SAMPLE_W-1:0] in_sample,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic [SAMPLE_W-1:0] out_mean,
  output int                  mismatch_count,
  output int                  means_pending
);

  localparam int MAX_REPORTS = 10;

  logic [SAMPLE_W-1:0]  sample_window [WINDOW];
  logic [31:0]          window_sum;
  int unsigned          write_slot;
  logic [PREFILL_W-1:0] seed_left;
  logic [SAMPLE_W-1:0]  expected_means [$];
  logic [SAMPLE_W-1:0]  wanted_mean;

  // Advance the window by one sample and return the truncated mean.
  function automatic logic [SAMPLE_W-1:0] next_mean(input logic [SAMPLE_W-1:0] s);
    if (seed_left != 0) begin
      // seed the whole window so the mean equals the sample
      seed_left = seed_left - 1'b1;
      for (int i = 0; i < WINDOW; i++) sample_window[i] = s;
      window_sum = 32'(s) * WINDOW;
    end
    window_sum = window_sum - sample_window[write_slot] + s;
    sample_window[write_slot] = s;
    write_slot = (write_slot + 1) % WINDOW;
    return SAMPLE_W'(window_sum / WINDOW);
  endfunction

  task automatic note_mismatch(input string what);
    if (mismatch_count < MAX_REPORTS) $display("%0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WINDOW; i++) sample_window[i] = '0;
      window_sum     = '0;
      write_slot     = 0;
      seed_left      = PREFILL_W'(PREFILL_COUNT);
      mismatch_count = 0;
      expected_means.delete();
      means_pending <= 0;
    end else begin
      // retire the oldest expectation before queueing a new one
      if (out_valid && !out_stall) begin
        if (expected_means.size() == 0) begin
          note_mismatch($sformatf("mean with no sample pending: expected none, got %0d",
                                  out_mean));
        end else begin
          wanted_mean = expected_means.pop_front();
          if (out_mean !== wanted_mean)
            note_mismatch($sformatf("mean mismatch: expected %0d, got %0d",
                                    wanted_mean, out_mean));
        end
      end
      if (in_valid && !in_stall) expected_means.push_back(next_mean(in_sample));
      means_pending <= expected_means.size();
    end
  end

endmodule

/* bench/moving_average_ring_filter_core_tb.sv */
`timescale 1ns / 1ps
// Testbench top for moving_average_ring_filter_core: drives directed and random
// sample streams with random idling and gives the verdict. Needs the checker and mavg_pkg.
module moving_average_ring_filter_core_tb import mavg_pkg::*;;

  localparam int WINDOW           = 100;
  localparam int PREFILL_COUNT    = 5;
  localparam int CLK_PERIOD       = 4;
  localparam int RESET_CYCLES     = 9;
  localparam int ITEM_TARGET      = 1800;
  localparam int HOLD_AT          = 1500;
  localparam int LONG_HOLD_CYCLES = 80;
  localparam int DRAIN_CYCLES     = 8;
  localparam int CYCLE_LIMIT      = 200_000;
  localparam int SAMPLE_MAX       = (1 << SAMPLE_W) - 1;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  logic [SAMPLE_W-1:0] in_sample = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [SAMPLE_W-1:0] out_mean;

  int mismatch_count;
  int means_pending;
  int samples_sent  = 0;
  int tx_idle_pct   = 0;
  int rx_stall_pct  = 0;
  int cycle_count   = 0;
  int hold_left     = 0;
  logic hold_request = 1'b0;
  logic hold_taken   = 1'b0;

  logic [SAMPLE_W-1:0] directed [] = '{
    12'd0, 12'hFFF, 12'hAAA, 12'h555, 12'h800,
    12'hFFF, 12'h000, 12'h001, 12'hFFE, 12'hFFF, 12'hFFF, 12'hAAA, 12'h555,
    12'h800, 12'h7FF, 12'h000, 12'h000, 12'hFFF, 12'h001, 12'h800
  };

  always #(CLK_PERIOD / 2) clk = ~clk;

  moving_average_ring_filter_core #(
    .WINDOW       (WINDOW),
    .PREFILL_COUNT(PREFILL_COUNT)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_sample(in_sample),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_mean (out_mean)
  );

  moving_average_ring_filter_core_checker #(
    .WINDOW       (WINDOW),
    .PREFILL_COUNT(PREFILL_COUNT)
  ) mean_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_sample     (in_sample),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_mean      (out_mean),
    .mismatch_count(mismatch_count),
    .means_pending (means_pending)
  );

  // Offer one sample, idling first at the current rate, and hold it until taken.
  task automatic send_sample(input logic [SAMPLE_W-1:0] sample);
    if (samples_sent < ITEM_TARGET / 3) begin
      tx_idle_pct = 11;
      rx_stall_pct <= 63;
    end else if (samples_sent < 2 * ITEM_TARGET / 3) begin
      tx_idle_pct = 63;
      rx_stall_pct <= 11;
    end else begin
      tx_idle_pct = 0;
      rx_stall_pct <= 0;
    end
    if (samples_sent == HOLD_AT) hold_request <= 1'b1;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= sample;
    do @(posedge clk); while (in_stall);
    samples_sent++;
  endtask

  // Result side: random stall, plus one long hold-off to back the block up.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_request && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left  <= LONG_HOLD_CYCLES;
      out_stall  <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("moving_average_ring_filter_core_tb: FAIL");
      $finish;
    end
  end

  initial begin
    int kind;
    int run_len;
    int base;
    int level;
    logic [SAMPLE_W-1:0] sample;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // the first PREFILL_COUNT of these seed the window
    foreach (directed[i]) send_sample(directed[i]);

    while (samples_sent < ITEM_TARGET) begin
      kind = $urandom_range(0, 19);
      base = $urandom_range(0, SAMPLE_MAX);
      if (kind < 2) run_len = $urandom_range(WINDOW, WINDOW + 30);
      else run_len = $urandom_range(1, 40);
      for (int j = 0; j < run_len && samples_sent < ITEM_TARGET; j++) begin
        case (kind)
          0: sample = SAMPLE_W'(SAMPLE_MAX);  // drive the sum to its top
          1: sample = '0;
          2, 3: sample = (j % 2) ? SAMPLE_W'(SAMPLE_MAX) : '0;
          4, 5, 6: begin
            level = base + $urandom_range(0, 32) - 16;
            if (level < 0) level = 0;
            if (level > SAMPLE_MAX) level = SAMPLE_MAX;
            sample = SAMPLE_W'(level);
          end
          7: sample = SAMPLE_W'(1 << $urandom_range(0, SAMPLE_W - 1));
          default: sample = SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
        endcase
        send_sample(sample);
      end
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (means_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && means_pending == 0) begin
      $display("moving_average_ring_filter_core_tb: PASS");
    end else begin
      $display("moving_average_ring_filter_core_tb: FAIL");
    end
    $finish;
  end

endmodule
